// File: rtl/core/bdhe_pkg.sv
// bdhe_pkg: shared types, constants and the hat code lookup for the debounce core
// used by every file under rtl/core, no dependencies
package bdhe_pkg;

  localparam int CNT_W    = 8;
  localparam int NUM_DPAD = 4;
  localparam int HAT_W    = 4;

  localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd5;

  localparam logic [HAT_W-1:0] HAT_CENTER     = 4'd0;
  localparam logic [HAT_W-1:0] HAT_UP         = 4'd1;
  localparam logic [HAT_W-1:0] HAT_UP_RIGHT   = 4'd2;
  localparam logic [HAT_W-1:0] HAT_RIGHT      = 4'd3;
  localparam logic [HAT_W-1:0] HAT_DOWN_RIGHT = 4'd4;
  localparam logic [HAT_W-1:0] HAT_DOWN       = 4'd5;
  localparam logic [HAT_W-1:0] HAT_DOWN_LEFT  = 4'd6;
  localparam logic [HAT_W-1:0] HAT_LEFT       = 4'd7;
  localparam logic [HAT_W-1:0] HAT_UP_LEFT    = 4'd8;

  // dpad mask bits: up, right, down, left
  localparam logic [NUM_DPAD-1:0] DIR_UP         = 4'b0001;
  localparam logic [NUM_DPAD-1:0] DIR_RIGHT      = 4'b0010;
  localparam logic [NUM_DPAD-1:0] DIR_DOWN       = 4'b0100;
  localparam logic [NUM_DPAD-1:0] DIR_LEFT       = 4'b1000;
  localparam logic [NUM_DPAD-1:0] DIR_UP_RIGHT   = 4'b0011;
  localparam logic [NUM_DPAD-1:0] DIR_DOWN_RIGHT = 4'b0110;
  localparam logic [NUM_DPAD-1:0] DIR_DOWN_LEFT  = 4'b1100;
  localparam logic [NUM_DPAD-1:0] DIR_UP_LEFT    = 4'b1001;

  typedef struct packed {
    logic             accept;
    logic [CNT_W-1:0] threshold;
  } lane_ctrl_t;

  function automatic logic [HAT_W-1:0] hat_encode(input logic [NUM_DPAD-1:0] dirs);
    logic [HAT_W-1:0] code;
    case (dirs)
      DIR_UP:         code = HAT_UP;
      DIR_UP_RIGHT:   code = HAT_UP_RIGHT;
      DIR_RIGHT:      code = HAT_RIGHT;
      DIR_DOWN_RIGHT: code = HAT_DOWN_RIGHT;
      DIR_DOWN:       code = HAT_DOWN;
      DIR_DOWN_LEFT:  code = HAT_DOWN_LEFT;
      DIR_LEFT:       code = HAT_LEFT;
      DIR_UP_LEFT:    code = HAT_UP_LEFT;
      default:        code = HAT_CENTER;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/core/bdhe_if.sv
// bdhe_if: valid/ready channel interfaces for pin samples and debounced results
// depends on bdhe_pkg for the hat code width
interface bdhe_in_if #(
  parameter int NUM_BUTTONS = 10
);
  logic                         valid;
  logic                         ready;
  logic [NUM_BUTTONS-1:0]       button_levels;
  logic [bdhe_pkg::NUM_DPAD-1:0] dpad_levels;

  modport source (output valid, output button_levels, output dpad_levels, input ready);
  modport sink   (input valid, input button_levels, input dpad_levels, output ready);
endinterface

interface bdhe_out_if #(
  parameter int NUM_BUTTONS = 10
);
  logic                       valid;
  logic                       ready;
  logic [NUM_BUTTONS-1:0]     pressed_mask;
  logic [bdhe_pkg::HAT_W-1:0] hat_code;

  modport source (output valid, output pressed_mask, output hat_code, input ready);
  modport sink   (input valid, input pressed_mask, input hat_code, output ready);
endinterface

// File: rtl/core/bdhe_lane.sv
// bdhe_lane: one debounce channel, stored level and saturating stability count
// depends on bdhe_pkg
module bdhe_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bdhe_pkg::lane_ctrl_t ctrl,
  input  logic                 pin_level,
  output logic                 pressed
);

  logic                       level_r, level_nxt;
  logic [bdhe_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                       sample;

  assign sample = ~pin_level;

  always_comb begin
    level_nxt = level_r;
    count_nxt = count_r;
    if (sample == level_r) begin
      if (count_r < ctrl.threshold) begin
        count_nxt = count_r + 1'b1;
      end
    end else begin
      level_nxt = sample;
      count_nxt = {{(bdhe_pkg::CNT_W-1){1'b0}}, 1'b1};
    end
  end

  // result of this word, taken from the updated state
  assign pressed = (count_nxt >= ctrl.threshold) && level_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b0;
      count_r <= '0;
    end else if (ctrl.accept) begin
      level_r <= level_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/core/bdhe_merge.sv
// bdhe_merge: combines lane results into the pressed mask and hat code, output register
// depends on bdhe_pkg for the hat lookup
module bdhe_merge #(
  parameter int NUM_BUTTONS = 10
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic [NUM_BUTTONS-1:0]        btn_pressed,
  input  logic [bdhe_pkg::NUM_DPAD-1:0] dir_pressed,
  output logic [NUM_BUTTONS-1:0]        pressed_mask,
  output logic [bdhe_pkg::HAT_W-1:0]    hat_code
);

  logic [NUM_BUTTONS-1:0]     mask_r;
  logic [bdhe_pkg::HAT_W-1:0] hat_r;

  always_ff @(posedge clk) begin
    if (load) begin
      mask_r <= btn_pressed;
      hat_r  <= bdhe_pkg::hat_encode(dir_pressed);
    end
  end

  assign pressed_mask = mask_r;
  assign hat_code     = hat_r;

endmodule

// File: rtl/core/button_debounce_hat_encoder_core.sv
// button_debounce_hat_encoder_core: debounced button mask and d-pad hat code
// depends on bdhe_pkg, bdhe_if, bdhe_lane, bdhe_merge
//
// in_chan carries one poll sample per word: raw active-low button and d-pad
// pin levels. out_chan returns one word per sample: the debounced pressed
// mask in input bit order and the hat code (0 centered, 1 up, clockwise to
// 8 up-left; opposite or three and more directions read as centered).
// cfg_we/cfg_wdata write the stability threshold, 5 after reset.
// One lane per pin updates its level and count in the cycle a word is
// accepted; the result sits in the output register from the next cycle.
// Throughput one word per cycle while out_chan takes each result, set by
// the single stage of per-pin counters feeding the output register.
// in_chan.ready stays high while the output register is empty or being
// taken; a stalled receiver holds the result and blocks only the next word.
// Reset clears all levels to released, all counts to zero, the output valid.
module button_debounce_hat_encoder_core #(
  parameter int NUM_BUTTONS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bdhe_in_if.sink                    in_chan,
  bdhe_out_if.source                 out_chan,
  input  logic                       cfg_we,
  input  logic [bdhe_pkg::CNT_W-1:0] cfg_wdata
);

  logic [bdhe_pkg::CNT_W-1:0]    threshold_r;
  logic                          out_valid_r, out_valid_nxt;
  logic                          accept;
  logic [NUM_BUTTONS-1:0]        btn_pressed;
  logic [bdhe_pkg::NUM_DPAD-1:0] dir_pressed;
  bdhe_pkg::lane_ctrl_t          ctrl;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign ctrl.accept    = accept;
  assign ctrl.threshold = threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= bdhe_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold_r <= cfg_wdata;
    end
  end

  genvar g;
  generate
    for (g = 0; g < NUM_BUTTONS; g++) begin : g_btn
      bdhe_lane u_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .pin_level (in_chan.button_levels[g]),
        .pressed   (btn_pressed[g])
      );
    end
    for (g = 0; g < bdhe_pkg::NUM_DPAD; g++) begin : g_dir
      bdhe_lane u_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .pin_level (in_chan.dpad_levels[g]),
        .pressed   (dir_pressed[g])
      );
    end
  endgenerate

  bdhe_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk          (clk),
    .load         (accept),
    .btn_pressed  (btn_pressed),
    .dir_pressed  (dir_pressed),
    .pressed_mask (out_chan.pressed_mask),
    .hat_code     (out_chan.hat_code)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;

endmodule
